// ----- hdl/tepq_pkg.sv -----
// shared types and constants for the timer expiry priority queue
// no dependencies; imported by every module of the block
package tepq_pkg;

    localparam int DEPTH_DEF     = 64;
    localparam int TIME_BITS_DEF = 32;
    localparam int ID_BITS_DEF   = 16;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] STATUS_ACK     = 2'd0;
    localparam logic [1:0] STATUS_EXPIRED = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] trigger_time;
        logic [15:0] timer_tag;
        logic [31:0] now_time;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] expired_id;
        logic [31:0] expired_time;
        logic        last;
    } t_result;

    // what every cell of the chain does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT,
        CELL_CLEAR
    } t_cell_op;

    typedef enum logic {
        S_IDLE,
        S_POP
    } t_state;

endpackage

// ----- hdl/tepq_cell.sv -----
// one slot of the sorted timer chain: valid bit, trigger time and id
// depends on tepq_pkg for the cell operation type
module tepq_cell
    import tepq_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int ID_BITS   = ID_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_op             i_op,
    input  logic [TIME_BITS-1:0] i_new_time,
    input  logic [ID_BITS-1:0]   i_new_id,
    // left neighbor (earlier slot)
    input  logic                 i_left_valid,
    input  logic                 i_left_gt,
    input  logic [TIME_BITS-1:0] i_left_time,
    input  logic [ID_BITS-1:0]   i_left_id,
    // right neighbor (later slot)
    input  logic                 i_right_valid,
    input  logic [TIME_BITS-1:0] i_right_time,
    input  logic [ID_BITS-1:0]   i_right_id,
    output logic                 o_valid,
    output logic                 o_gt,
    output logic [TIME_BITS-1:0] o_time,
    output logic [ID_BITS-1:0]   o_id
);

    logic                 r_valid, n_valid;
    logic [TIME_BITS-1:0] r_time, n_time;
    logic [ID_BITS-1:0]   r_id, n_id;
    logic                 gt;

    // strictly later than the new timer, so equal times keep insertion order
    assign gt = r_valid && (r_time > i_new_time);

    always_comb begin
        n_valid = r_valid;
        n_time  = r_time;
        n_id    = r_id;
        case (i_op)
            CELL_INSERT: begin
                if (i_left_gt) begin
                    n_valid = 1'b1;
                    n_time  = i_left_time;
                    n_id    = i_left_id;
                end else if (gt || (!r_valid && i_left_valid)) begin
                    n_valid = 1'b1;
                    n_time  = i_new_time;
                    n_id    = i_new_id;
                end
            end
            CELL_SHIFT: begin
                n_valid = i_right_valid;
                n_time  = i_right_time;
                n_id    = i_right_id;
            end
            CELL_CLEAR: begin
                n_valid = 1'b0;
            end
            default: begin
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_time <= n_time;
        r_id   <= n_id;
    end

    assign o_valid = r_valid;
    assign o_gt    = gt;
    assign o_time  = r_time;
    assign o_id    = r_id;

endmodule

// ----- hdl/timer_expiry_priority_queue.sv -----
// top level of the timer expiry priority queue: command decode and pop sequencer
// depends on tepq_pkg and on the tepq_cell chain
//
// usage:
//   a command transfer happens at a rising edge with start high and busy low.
//   add inserts a timer; clear empties the store.
//   update pops every stored timer whose trigger time is at or before now_time,
//   earliest first, one per cycle from the head of the cell chain.
//   every command yields its first result on o_result with o_strobe in the cycle
//   after the transfer; an update with n due timers yields n results back to back
//   (one result if nothing is due), last set on the final one.
//   busy is high while further pops of an update are pending.
//   the pop rate is set by the one-slot shift of the chain per cycle.
//   an add into a full store drops the timer and answers status full.
//   reset empties the store at once and clears the strobe and sequencer.
//   results must be taken in the cycle they are shown; there is no stall.
module timer_expiry_priority_queue
    import tepq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int ID_BITS   = ID_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_cmd    i_cmd,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    t_state               r_state, n_state;
    logic [TIME_BITS-1:0] r_now;
    logic                 r_strobe, n_strobe;
    t_result              r_result, n_result;
    t_cell_op             cell_op;

    logic [DEPTH-1:0]                 cell_valid;
    logic [DEPTH-1:0]                 cell_gt;
    logic [DEPTH-1:0][TIME_BITS-1:0]  cell_time;
    logic [DEPTH-1:0][ID_BITS-1:0]    cell_id;

    logic                 accept;
    logic [TIME_BITS-1:0] new_time;
    logic [ID_BITS-1:0]   new_id;
    logic [TIME_BITS-1:0] now_sel;
    logic                 head_due;
    logic                 next_due;
    logic                 full;

    assign accept   = start && !busy;
    assign new_time = TIME_BITS'(i_cmd.trigger_time);
    assign new_id   = ID_BITS'(i_cmd.timer_tag);
    assign now_sel  = (r_state == S_POP) ? r_now : TIME_BITS'(i_cmd.now_time);
    assign head_due = cell_valid[0] && (cell_time[0] <= now_sel);
    assign next_due = cell_valid[1] && (cell_time[1] <= now_sel);
    assign full     = cell_valid[DEPTH-1];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic                 left_valid, left_gt, right_valid;
            logic [TIME_BITS-1:0] left_time, right_time;
            logic [ID_BITS-1:0]   left_id, right_id;

            if (g == 0) begin : g_first
                // the head has an always-valid, never-later phantom on its left
                assign left_valid = 1'b1;
                assign left_gt    = 1'b0;
                assign left_time  = '0;
                assign left_id    = '0;
            end else begin : g_inner
                assign left_valid = cell_valid[g-1];
                assign left_gt    = cell_gt[g-1];
                assign left_time  = cell_time[g-1];
                assign left_id    = cell_id[g-1];
            end

            if (g == DEPTH - 1) begin : g_tail
                assign right_valid = 1'b0;
                assign right_time  = '0;
                assign right_id    = '0;
            end else begin : g_body
                assign right_valid = cell_valid[g+1];
                assign right_time  = cell_time[g+1];
                assign right_id    = cell_id[g+1];
            end

            tepq_cell #(
                .TIME_BITS (TIME_BITS),
                .ID_BITS   (ID_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_op          (cell_op),
                .i_new_time    (new_time),
                .i_new_id      (new_id),
                .i_left_valid  (left_valid),
                .i_left_gt     (left_gt),
                .i_left_time   (left_time),
                .i_left_id     (left_id),
                .i_right_valid (right_valid),
                .i_right_time  (right_time),
                .i_right_id    (right_id),
                .o_valid       (cell_valid[g]),
                .o_gt          (cell_gt[g]),
                .o_time        (cell_time[g]),
                .o_id          (cell_id[g])
            );
        end
    endgenerate

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_cmd.op == OP_UPDATE) && head_due && next_due) begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (!next_due) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and chain control
    always_comb begin
        cell_op  = CELL_HOLD;
        n_strobe = 1'b0;
        n_result = '{status: STATUS_ACK, expired_id: '0, expired_time: '0, last: 1'b1};
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_strobe = 1'b1;
                    unique case (i_cmd.op)
                        OP_ADD: begin
                            if (full) begin
                                n_result.status = STATUS_FULL;
                            end else begin
                                cell_op = CELL_INSERT;
                            end
                        end
                        OP_UPDATE: begin
                            if (head_due) begin
                                cell_op               = CELL_SHIFT;
                                n_result.status       = STATUS_EXPIRED;
                                n_result.expired_id   = 16'(cell_id[0]);
                                n_result.expired_time = 32'(cell_time[0]);
                                n_result.last         = !next_due;
                            end
                        end
                        OP_CLEAR: begin
                            cell_op = CELL_CLEAR;
                        end
                        default: begin
                            cell_op = CELL_HOLD;
                        end
                    endcase
                end
            end
            S_POP: begin
                // head is known due: it was checked as the second slot last cycle
                cell_op               = CELL_SHIFT;
                n_strobe              = 1'b1;
                n_result.status       = STATUS_EXPIRED;
                n_result.expired_id   = 16'(cell_id[0]);
                n_result.expired_time = 32'(cell_time[0]);
                n_result.last         = !next_due;
            end
            default: begin
                cell_op = CELL_HOLD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (accept) begin
            r_now <= TIME_BITS'(i_cmd.now_time);
        end
    end

    assign busy     = (r_state == S_POP);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ----- hdl/tepq_checker.sv -----
// port-level checks for the timer expiry priority queue, bound to the top level
// depends on tepq_pkg for the command, result and status definitions
module tepq_checker
    import tepq_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input t_cmd    i_cmd,
    input logic    busy,
    input logic    o_strobe,
    input t_result o_result
);

    // every accepted command shows its first result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_strobe)
        else $error("no result after command transfer");

    // an unfinished update keeps busy high and pops again next cycle
    a_pop_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |-> busy ##1 o_strobe)
        else $error("expired timer sequence broken");

    // busy only while a multi-result update is being shown
    a_busy_in_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (o_strobe && !o_result.last && o_result.status == STATUS_EXPIRED))
        else $error("busy without pending expired timers");

    // timers leave earliest first within one update
    a_time_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == STATUS_EXPIRED && !o_result.last)
            |=> (o_result.expired_time >= $past(o_result.expired_time)))
        else $error("expired timers out of order");

    // results without a timer carry zero fields
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status != STATUS_EXPIRED)
            |-> (o_result.expired_id == '0 && o_result.expired_time == '0
                 && o_result.last))
        else $error("non-timer result with nonzero fields");

endmodule

bind timer_expiry_priority_queue tepq_checker u_tepq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_cmd    (i_cmd),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

// ----- tb/timer_expiry_priority_queue_test.sv -----
// self-checking test of timer_expiry_priority_queue: directed, overflow and random command runs
// depends on tepq_pkg and the timer_expiry_priority_queue rtl; results are checked against a
// timer store kept in this bench in firing order
module timer_expiry_priority_queue_test;
    import tepq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         MAX_CYCLES = 200000;
    localparam logic [31:0] T_MAX     = 32'hFFFF_FFFF;

    typedef struct {
        logic [31:0] trig;
        logic [15:0] tid;
    } t_timer;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    start;
    t_cmd    i_cmd;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    t_timer      timer_store[$];
    t_result     due_results[$];
    int unsigned idle_pct;
    int unsigned error_count;
    int unsigned cycle_count;
    logic [31:0] time_base;

    timer_expiry_priority_queue u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("timer_expiry_priority_queue regression: fail");
            $finish;
        end
    end

    function automatic t_cmd mk_cmd(input logic [1:0] op, input logic [31:0] trig,
                                    input logic [15:0] tid, input logic [31:0] now);
        t_cmd c;
        c.op           = op;
        c.trigger_time = trig;
        c.timer_tag    = tid;
        c.now_time     = now;
        return c;
    endfunction

    function automatic t_result mk_result(input logic [1:0] status, input logic [15:0] tid,
                                          input logic [31:0] trig, input logic last);
        t_result r;
        r.status       = status;
        r.expired_id   = tid;
        r.expired_time = trig;
        r.last         = last;
        return r;
    endfunction

    // append one expected result behind those already waiting
    function automatic void add_expected(input t_result r);
        due_results.insert(due_results.size(), r);
    endfunction

    // apply one accepted command to the bench copy of the store
    function automatic void schedule_cmd(input t_cmd c);
        int     pos;
        int     n;
        t_timer e;
        case (c.op)
            OP_ADD: begin
                if (timer_store.size() >= DEPTH_DEF) begin
                    add_expected(mk_result(STATUS_FULL, '0, '0, 1'b1));
                end else begin
                    // equal times go behind the ones already stored
                    pos = timer_store.size();
                    while (pos > 0 && timer_store[pos-1].trig > c.trigger_time)
                        pos--;
                    e.trig = c.trigger_time;
                    e.tid  = c.timer_tag;
                    timer_store.insert(pos, e);
                    add_expected(mk_result(STATUS_ACK, '0, '0, 1'b1));
                end
            end
            OP_UPDATE: begin
                n = 0;
                while (n < timer_store.size() && timer_store[n].trig <= c.now_time)
                    n++;
                if (n == 0)
                    add_expected(mk_result(STATUS_ACK, '0, '0, 1'b1));
                for (int i = 0; i < n; i++) begin
                    e = timer_store.pop_front();
                    add_expected(mk_result(STATUS_EXPIRED, e.tid, e.trig, (i == n - 1)));
                end
            end
            OP_CLEAR: begin
                timer_store.delete();
                add_expected(mk_result(STATUS_ACK, '0, '0, 1'b1));
            end
            default: begin
                add_expected(mk_result(STATUS_ACK, '0, '0, 1'b1));
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (due_results.size() == 0) begin
                report_mismatch("unexpected result status", 32'(o_result.status), '0);
            end else begin
                want = due_results.pop_front();
                if (o_result.status !== want.status)
                    report_mismatch("status", 32'(o_result.status), 32'(want.status));
                if (o_result.expired_id !== want.expired_id)
                    report_mismatch("expired_id", 32'(o_result.expired_id),
                                    32'(want.expired_id));
                if (o_result.expired_time !== want.expired_time)
                    report_mismatch("expired_time", o_result.expired_time, want.expired_time);
                if (o_result.last !== want.last)
                    report_mismatch("last", 32'(o_result.last), 32'(want.last));
            end
        end
    end

    // hold the command until a transfer, then maybe leave a gap with noise on the bus
    task automatic send_cmd(input t_cmd c);
        logic taken;
        taken = 1'b0;
        start <= 1'b1;
        i_cmd <= c;
        // busy only moves after a rising edge, so its value mid-cycle is the one the edge sees
        while (!taken) begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end
        schedule_cmd(c);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            i_cmd <= mk_cmd(2'($urandom), $urandom, 16'($urandom), $urandom);
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic test_directed();
        send_cmd(mk_cmd(OP_UPDATE, 32'h1234_5678, 16'hBEEF, T_MAX));
        send_cmd(mk_cmd(OP_UNUSED, 32'h0000_0001, 16'h0001, 32'h0));
        send_cmd(mk_cmd(OP_ADD, 32'h0, 16'h0, T_MAX));
        send_cmd(mk_cmd(OP_ADD, T_MAX, 16'hFFFF, 32'h0));
        // three ties must leave in insertion order
        send_cmd(mk_cmd(OP_ADD, 32'd100, 16'd1, 32'h0));
        send_cmd(mk_cmd(OP_ADD, 32'd100, 16'd2, 32'h0));
        send_cmd(mk_cmd(OP_ADD, 32'd100, 16'd3, 32'h0));
        send_cmd(mk_cmd(OP_ADD, 32'd50, 16'd4, 32'h0));
        send_cmd(mk_cmd(OP_UPDATE, T_MAX, 16'hFFFF, 32'd0));
        send_cmd(mk_cmd(OP_UPDATE, 32'h0, 16'h0, 32'd99));
        send_cmd(mk_cmd(OP_UPDATE, 32'h0, 16'h0, 32'd100));
        send_cmd(mk_cmd(OP_UPDATE, 32'h0, 16'h0, 32'hFFFF_FFFE));
        send_cmd(mk_cmd(OP_UPDATE, 32'h0, 16'h0, T_MAX));
        send_cmd(mk_cmd(OP_ADD, 32'd7, 16'h5555, 32'hAAAA_AAAA));
        send_cmd(mk_cmd(OP_ADD, 32'd7, 16'hAAAA, 32'h5555_5555));
        send_cmd(mk_cmd(OP_CLEAR, 32'h5555_5555, 16'h5555, 32'hAAAA_AAAA));
        send_cmd(mk_cmd(OP_UPDATE, 32'h0, 16'h0, T_MAX));
        send_cmd(mk_cmd(OP_UNUSED, T_MAX, 16'hFFFF, T_MAX));
        send_cmd(mk_cmd(OP_ADD, T_MAX, 16'h0, 32'h0));
        send_cmd(mk_cmd(OP_UPDATE, 32'h0, 16'h0, 32'h0));
        send_cmd(mk_cmd(OP_CLEAR, 32'h0, 16'h0, 32'h0));
    endtask

    // fill the store with many ties, overflow it, then drain it in one update
    task automatic test_full_store();
        logic [31:0] base;
        base = $urandom;
        send_cmd(mk_cmd(OP_CLEAR, $urandom, 16'($urandom), $urandom));
        for (int i = 0; i < DEPTH_DEF; i++)
            send_cmd(mk_cmd(OP_ADD, base + $urandom_range(0, 7), 16'($urandom), $urandom));
        repeat (3)
            send_cmd(mk_cmd(OP_ADD, $urandom, 16'($urandom), $urandom));
        send_cmd(mk_cmd(OP_UPDATE, $urandom, 16'($urandom), T_MAX));
        send_cmd(mk_cmd(OP_UPDATE, $urandom, 16'($urandom), T_MAX));
    endtask

    task automatic test_random(input int unsigned count);
        int unsigned pick;
        logic [31:0] trig;
        logic [31:0] now;
        for (int unsigned k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            trig = ($urandom_range(99) < 20) ? $urandom : time_base + $urandom_range(0, 4096);
            if ($urandom_range(99) < 10)
                now = ($urandom_range(1) != 0) ? T_MAX : $urandom;
            else
                now = time_base + $urandom_range(0, 2048);
            if (pick < 52) begin
                send_cmd(mk_cmd(OP_ADD, trig, 16'($urandom), $urandom));
            end else if (pick < 90) begin
                send_cmd(mk_cmd(OP_UPDATE, $urandom, 16'($urandom), now));
                time_base = time_base + $urandom_range(0, 1024);
            end else if (pick < 95) begin
                send_cmd(mk_cmd(OP_CLEAR, $urandom, 16'($urandom), $urandom));
            end else begin
                send_cmd(mk_cmd(OP_UNUSED, $urandom, 16'($urandom), $urandom));
            end
        end
    endtask

    initial begin
        int unsigned phase_idle[3];
        phase_idle  = '{0, 45, 31};
        error_count = 0;
        cycle_count = 0;
        idle_pct    = 0;
        time_base   = $urandom;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_cmd   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        foreach (phase_idle[p]) begin
            idle_pct = phase_idle[p];
            test_random(70);
        end
        test_full_store();

        start <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (error_count == 0)
            $display("timer_expiry_priority_queue regression: pass");
        else
            $display("timer_expiry_priority_queue regression: fail");
        $finish;
    end

endmodule
